// File: hdl/mvpt_pkg.sv
// Package for the multi-voice pulse tone player: sizes, codes, tables.
// No dependencies.
package mvpt_pkg;

  localparam int unsigned Voices        = 4;
  localparam int unsigned NotesPerVoice = 256;
  localparam int unsigned LoopGranule   = 256;
  localparam int unsigned SampleRateHz  = 16000;

  localparam int unsigned VoiceW = $clog2(Voices);
  localparam int unsigned EntryW = $clog2(NotesPerVoice);
  localparam int unsigned AddrW  = VoiceW + EntryW;
  localparam int unsigned PosW   = EntryW + 1;
  localparam int unsigned NoteW  = 39;
  localparam int unsigned CntW   = 21;
  localparam int unsigned VstW   = PosW + 64;

  localparam int unsigned SamplesPerMs = SampleRateHz / 1000;
  localparam int signed   PulseAmp     = 5500;
  localparam logic [31:0] DutyLimit    = 32'h4000_0000;

  // register indexes
  localparam logic [2:0] RegVoices = 3'd0;
  localparam logic [2:0] RegLen0   = 3'd1;
  localparam logic [2:0] RegLen3   = 3'd4;
  localparam logic [2:0] RegTune   = 3'd5;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeTick = 1'b1;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  pitch;
    logic [15:0] start;
    logic [15:0] dur;
  } note_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [31:0]     phase;
    logic [31:0]     step;
  } vstate_t;

  // step = (440*semi[p%12] shifted by octave) << 24 / SampleRateHz, per pitch
  function automatic logic [31:0] pitch_step(input logic [6:0] pitch);
    logic [63:0] freq;
    int unsigned p;
    int          oct;
    int unsigned semi [12];
    begin
      semi = '{256, 271, 287, 304, 322, 341, 362, 383, 406, 430, 456, 483};
      p = int'(pitch) + 3;
      oct = int'(p / 12) - 6;
      freq = 64'(440 * semi[p % 12]);
      if (oct >= 0) freq = freq << oct;
      else          freq = freq >> (-oct);
      pitch_step = 32'((freq[31:0] * 64'(1 << 24)) / 64'(SampleRateHz));
    end
  endfunction

endpackage

// File: hdl/mvpt_if.sv
// Valid/ready channel interfaces for the tone player.
// Depends on mvpt_pkg.
interface mvpt_in_if;
  import mvpt_pkg::*;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  voice_sel;
  logic [7:0]  entry_index;
  logic [6:0]  pitch;
  logic [15:0] start_time_ms;
  logic [15:0] duration_ms;
  modport source (output valid, mode, voice_sel, entry_index, pitch, start_time_ms,
                  duration_ms, input ready);
  modport sink (input valid, mode, voice_sel, entry_index, pitch, start_time_ms,
                duration_ms, output ready);
endinterface

interface mvpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface mvpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/mvpt_ram.sv
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module mvpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/mvpt_step_rom.sv
// Registered lookup of the phase step for a pitch.
// Depends on mvpt_pkg.
module mvpt_step_rom import mvpt_pkg::*; (
  input  logic        clk_i,
  input  logic [6:0]  pitch_i,
  output logic [31:0] step_o
);
  logic [31:0] rom [128];

  always_comb begin
    for (int i = 0; i < 128; i++) rom[i] = pitch_step(7'(i));
  end

  always_ff @(posedge clk_i) step_o <= rom[pitch_i];
endmodule

// File: hdl/multi_voice_pulse_tone_player_core.sv
// Top level of the multi-voice pulse tone player.
// Depends on mvpt_pkg, mvpt_if, mvpt_ram, mvpt_step_rom.
//
//  channel  | dir | payload
//  in_ch    | in  | mode, voice_sel, entry_index, pitch, start_time_ms, duration_ms
//  out_ch   | out | sample
//  cfg_ch   | in  | index, data
//
// Items are taken in idle; a load writes the note table in its accepting cycle. A tick
// runs StTime, then per active voice (voices_in_use clamped to 4) StVRd and StNRd, then
// StTime if its notes are used up, else StEval, then StTime before its note starts, StStep
// while it sounds or StNRd (one RAM port, next note read) if it ended; StOut ends a tick.
// Reset clears counters and flags all voice state as zero; the note table is not cleared.
// A finished sample waits in the output register; a later tick stalls at its end until
// that register is free, and no loads are taken meanwhile.
module multi_voice_pulse_tone_player_core import mvpt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  mvpt_in_if.sink   in_ch,
  mvpt_out_if.source out_ch,
  mvpt_cfg_if.sink  cfg_ch
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StTime  = 7'b0000010,
    StVRd   = 7'b0000100,
    StNRd   = 7'b0001000,
    StEval  = 7'b0010000,
    StStep  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0]  nvoices_q;
  logic [8:0]  len_q [Voices];
  logic [15:0] tune_q;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvoices_q <= '0;
      tune_q <= '0;
      for (int i = 0; i < Voices; i++) len_q[i] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegVoices: nvoices_q <= cfg_ch.data[2:0];
        RegTune:   tune_q <= cfg_ch.data;
        default: begin
          if (cfg_ch.index >= RegLen0 && cfg_ch.index <= RegLen3)
            len_q[2'(cfg_ch.index - RegLen0)] <= cfg_ch.data[8:0];
        end
      endcase
    end
  end

  // loop length, registered
  logic [CntW-1:0] loop_q;
  logic [CntW-1:0] total;
  always_comb total = CntW'((32'(tune_q) + 32'd50) * SamplesPerMs + LoopGranule - 1);
  always_ff @(posedge clk_i) loop_q <= (total / CntW'(LoopGranule)) * CntW'(LoopGranule);

  // datapath registers
  logic [CntW-1:0]  cnt_q;
  logic [16:0]      t_q;
  logic [VoiceW:0]  k_q;
  logic [Voices-1:0] vvalid_q;
  logic signed [17:0] mix_q;
  vstate_t          vs_q;
  logic signed [15:0] samp_q;
  logic             ovalid_q;

  // note table and voice state memories
  logic            in_acc;
  logic            nt_we;
  note_t           nt_rd;
  logic [AddrW-1:0] nt_raddr;
  logic            vs_we;
  vstate_t         vs_rd, vs_wd;
  logic [31:0]     rom_step;

  assign in_ch.ready = (state_q == StIdle);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign nt_we = in_acc && (in_ch.mode == ModeLoad);
  assign nt_raddr = {k_q[VoiceW-1:0], vs_q.pos[EntryW-1:0]};

  mvpt_ram #(.Width(NoteW), .Depth(Voices * NotesPerVoice)) u_notes (
    .clk_i, .we_i(nt_we),
    .waddr_i({in_ch.voice_sel, in_ch.entry_index}),
    .wdata_i({in_ch.pitch, in_ch.start_time_ms, in_ch.duration_ms}),
    .raddr_i(nt_raddr), .rdata_o(nt_rd)
  );

  mvpt_ram #(.Width(VstW), .Depth(Voices)) u_vstate (
    .clk_i, .we_i(vs_we), .waddr_i(k_q[VoiceW-1:0]), .wdata_i(vs_wd),
    .raddr_i(k_q[VoiceW-1:0]), .rdata_o(vs_rd)
  );

  mvpt_step_rom u_rom (.clk_i, .pitch_i(nt_rd.pitch), .step_o(rom_step));

  // derived values
  logic [2:0]  nv;
  logic [8:0]  len;
  logic [16:0] nend;
  logic [16:0] left;
  logic signed [17:0] amp;
  logic [31:0] phase_n;
  assign nv = (nvoices_q > 3'(Voices)) ? 3'(Voices) : nvoices_q;
  assign len = (len_q[k_q[VoiceW-1:0]] > 9'(NotesPerVoice)) ? 9'(NotesPerVoice)
             : len_q[k_q[VoiceW-1:0]];
  assign nend = 17'(nt_rd.start) + 17'(nt_rd.dur);
  assign left = nend - t_q;
  assign phase_n = vs_q.phase + (vs_q.phase == '0 ? rom_step : vs_q.step);
  always_comb begin
    amp = 18'(PulseAmp);
    if (left < 17'd8) amp = 18'((PulseAmp * int'(left[2:0])) >>> 3);
  end

  // sequencer
  logic ntick;
  always_comb begin
    state_d = state_q;
    vs_we = 1'b0;
    vs_wd = vs_q;
    ntick = 1'b0;
    unique case (state_q)
      StIdle: if (in_acc && in_ch.mode == ModeTick) state_d = StTime;
      StTime: state_d = (k_q < 4'(nv)) ? StVRd : StOut;
      StVRd:  state_d = StNRd;
      StNRd: begin
        if (vs_q.pos >= PosW'(len)) begin
          vs_we = 1'b1;
          ntick = 1'b1;
          state_d = StTime;
        end else state_d = StEval;
      end
      StEval: begin
        if (t_q >= nend) state_d = StNRd;
        else if (t_q < 17'(nt_rd.start)) begin
          vs_we = 1'b1; ntick = 1'b1; state_d = StTime;
        end else state_d = StStep;
      end
      StStep: begin
        vs_we = 1'b1;
        vs_wd.phase = phase_n;
        if (vs_q.phase == '0) vs_wd.step = rom_step;
        ntick = 1'b1;
        state_d = StTime;
      end
      StOut: if (!ovalid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // voice state flags: every voice reads as zero from each loop start until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvalid_q <= '0;
    end else if (in_acc && in_ch.mode == ModeTick && cnt_q == '0) begin
      vvalid_q <= '0;
    end else if (vs_we) begin
      vvalid_q[k_q[VoiceW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      k_q <= '0;
      ovalid_q <= 1'b0;
      mix_q <= '0;
      vs_q <= '0;
      t_q <= '0;
      samp_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          k_q <= '0;
          mix_q <= '0;
          // t = cnt*1000/16000 = cnt/16
          t_q <= 17'(cnt_q >> 4);
        end
        StVRd: ;
        StNRd: if (state_d == StNRd || state_d == StEval) ;
        StStep: begin
          if ((phase_n < DutyLimit)) mix_q <= mix_q + amp;
          else mix_q <= mix_q - amp;
        end
        StOut: if (!ovalid_q) begin
          samp_q <= 16'(mix_q);
          ovalid_q <= 1'b1;
          cnt_q <= (cnt_q + 1'b1 >= loop_q) ? '0 : cnt_q + 1'b1;
        end
        default: ;
      endcase
      // voice state fetched in StVRd arrives in StNRd's first cycle
      if (state_q == StVRd) vs_q <= vvalid_q[k_q[VoiceW-1:0]] ? vs_rd : '0;
      if (state_q == StEval && t_q >= nend) begin
        vs_q.pos <= vs_q.pos + 1'b1;
        vs_q.phase <= '0;
      end
      if (ntick) k_q <= k_q + 1'b1;
    end
  end

  // StVRd takes the vs RAM word read at k; StNRd addresses the note RAM, which StVRd
  // cannot do yet, as pos arrives only then; the note data is used in StEval.
  assign out_ch.valid = ovalid_q;
  assign out_ch.sample = samp_q;
endmodule

// File: hdl/mvpt_checker.sv
// Port-level checker for the tone player, bound to the top level.
// Depends on multi_voice_pulse_tone_player_core ports.
module mvpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_mode_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i |=> !in_ready_i) else $error("tick not busy");
  a_noout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_mode_i && !out_valid_i |=> !out_valid_i)
    else $error("load made result");
endmodule

bind multi_voice_pulse_tone_player_core mvpt_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .in_mode_i(in_ch.mode), .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready)
);
